/* design/tmsf_pkg.sv */
// ---------------------------------------------------------------------------
// tmsf_pkg: shared types and constants for the trimmed-mean sample filter
// Field widths, register indexes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
`default_nettype none

package tmsf_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int SHIFT_W   = 4;
  localparam int CNT_W     = 7;
  localparam int SUM_W     = 18;
  localparam int DIV_W     = 6;
  localparam int STEP_W    = 5;
  localparam int BYTE_W    = 8;
  localparam int TDATA_W   = ((SAMPLE_W + BYTE_W - 1) / BYTE_W) * BYTE_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 7;

  localparam int MIN_BURST = 3;
  localparam int MAX_BURST = 64;

  localparam logic [CNT_W-1:0]   BURST_LEN_RST = CNT_W'(10);
  localparam logic [SHIFT_W-1:0] SHIFT_RST     = '0;
  localparam logic [STEP_W-1:0]  LAST_STEP     = STEP_W'(SUM_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_SHIFT = 1'b1;

  typedef struct packed {
    logic acc;       // fold accepted word into running stats
    logic fin;       // load divider, clear running stats
    logic div_step;  // one restoring divide step
    logic out_load;  // move quotient into output register
  } tmsf_cmd_t;

  typedef struct packed {
    logic burst_done;  // word being accepted completes the burst
    logic div_last;    // current divide step is the final one
  } tmsf_sts_t;

endpackage

`default_nettype wire

/* design/tmsf_ctrl.sv */
// ---------------------------------------------------------------------------
// tmsf_ctrl: sequencing state machine for the trimmed-mean sample filter
// Accept words, then run finish, divide and output phases at burst end.
// ---------------------------------------------------------------------------
`default_nettype none

module tmsf_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  input  tmsf_pkg::tmsf_sts_t sts,
  output tmsf_pkg::tmsf_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIN  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.acc = 1'b1;
          if (sts.burst_done) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/tmsf_dp.sv */
// ---------------------------------------------------------------------------
// tmsf_dp: datapath of the trimmed-mean sample filter
// Config registers, running count/sum/min/max, serial divider, output word.
// ---------------------------------------------------------------------------
`default_nettype none

module tmsf_dp (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire  [tmsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [tmsf_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  wire  [tmsf_pkg::SAMPLE_W-1:0]      in_sample,
  input  tmsf_pkg::tmsf_cmd_t                cmd,
  output tmsf_pkg::tmsf_sts_t                sts,
  output logic [tmsf_pkg::SAMPLE_W-1:0]      out_value
);

  logic [tmsf_pkg::CNT_W-1:0]    burst_len_r;
  logic [tmsf_pkg::SHIFT_W-1:0]  shift_r;
  logic [tmsf_pkg::CNT_W-1:0]    cnt_r;
  logic [tmsf_pkg::SUM_W-1:0]    sum_r;
  logic [tmsf_pkg::SAMPLE_W-1:0] min_r;
  logic [tmsf_pkg::SAMPLE_W-1:0] max_r;
  logic [tmsf_pkg::SUM_W-1:0]    quo_r;
  logic [tmsf_pkg::DIV_W-1:0]    rem_r;
  logic [tmsf_pkg::DIV_W-1:0]    dsr_r;
  logic [tmsf_pkg::STEP_W-1:0]   step_r;
  logic [tmsf_pkg::SAMPLE_W-1:0] out_r;

  logic [tmsf_pkg::SAMPLE_W-1:0] samp_sh;
  logic [tmsf_pkg::CNT_W-1:0]    n_eff;
  logic [tmsf_pkg::CNT_W-1:0]    cnt_nxt;
  logic [tmsf_pkg::CNT_W-1:0]    dsr_full;
  logic [tmsf_pkg::SUM_W-1:0]    trimmed;
  logic [tmsf_pkg::DIV_W:0]      trial;
  logic [tmsf_pkg::DIV_W:0]      trial_sub;
  logic                          quo_bit;

  // Clamp the configured burst length into the supported range.
  always_comb begin
    n_eff = burst_len_r;
    if (burst_len_r < tmsf_pkg::CNT_W'(tmsf_pkg::MIN_BURST))
      n_eff = tmsf_pkg::CNT_W'(tmsf_pkg::MIN_BURST);
    else if (burst_len_r > tmsf_pkg::CNT_W'(tmsf_pkg::MAX_BURST))
      n_eff = tmsf_pkg::CNT_W'(tmsf_pkg::MAX_BURST);
  end

  assign samp_sh        = in_sample >> shift_r;
  assign cnt_nxt        = cnt_r + tmsf_pkg::CNT_W'(1);
  assign sts.burst_done = (cnt_nxt >= n_eff);
  assign sts.div_last   = (step_r == tmsf_pkg::LAST_STEP);
  assign trimmed        = sum_r - tmsf_pkg::SUM_W'(min_r) - tmsf_pkg::SUM_W'(max_r);
  assign dsr_full       = n_eff - tmsf_pkg::CNT_W'(2);

  // Restoring divide: shift in one dividend bit, subtract if it fits.
  assign trial     = {rem_r, quo_r[tmsf_pkg::SUM_W-1]};
  assign trial_sub = trial - {1'b0, dsr_r};
  assign quo_bit   = (trial >= {1'b0, dsr_r});
  assign out_value = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_len_r <= tmsf_pkg::BURST_LEN_RST;
      shift_r     <= tmsf_pkg::SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tmsf_pkg::REG_BURST_LENGTH: burst_len_r <= cfg_data;
        tmsf_pkg::REG_RESULT_SHIFT: shift_r <= cfg_data[tmsf_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      min_r <= '1;
      max_r <= '0;
    end else if (cmd.fin) begin
      cnt_r <= '0;
      sum_r <= '0;
      min_r <= '1;
      max_r <= '0;
    end else if (cmd.acc) begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_r + tmsf_pkg::SUM_W'(samp_sh);
      if (samp_sh < min_r) min_r <= samp_sh;
      if (samp_sh > max_r) max_r <= samp_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      quo_r  <= trimmed;
      rem_r  <= '0;
      dsr_r  <= dsr_full[tmsf_pkg::DIV_W-1:0];
      step_r <= '0;
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[tmsf_pkg::SUM_W-2:0], quo_bit};
      rem_r  <= quo_bit ? trial_sub[tmsf_pkg::DIV_W-1:0] : trial[tmsf_pkg::DIV_W-1:0];
      step_r <= step_r + tmsf_pkg::STEP_W'(1);
    end
    if (cmd.out_load) out_r <= quo_r[tmsf_pkg::SAMPLE_W-1:0];
  end

endmodule

`default_nettype wire

/* design/trimmed_mean_sample_filter_core.sv */
// Timing: a word inside a burst is absorbed into the running stats when accepted;
// for the word ending a burst out_tvalid rises after a finish step, 18 restoring
// divide steps and an output load. Throughput: 1 word per cycle inside a burst;
// in_tready stays low from the last word of each burst until the result is loaded,
// longer while the previous result word still waits on out_tready.
// Reset: synchronous active-low rst_n clears stats, output valid and config.
// ---------------------------------------------------------------------------
// trimmed_mean_sample_filter_core: trimmed-mean sample filter, top level
// Shift each sample, track count/sum/min/max, emit (sum-min-max)/(N-2).
// ---------------------------------------------------------------------------
`default_nettype none

module trimmed_mean_sample_filter_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // Configuration write channel
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [tmsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [tmsf_pkg::CFG_DAT_W-1:0]      cfg_data,
  // Sample input stream
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [tmsf_pkg::TDATA_W-1:0]        in_tdata,   // [11:0] sample, [15:12] zero
  // Result stream
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [tmsf_pkg::TDATA_W-1:0]        out_tdata   // [11:0] filtered_value, [15:12] zero
);

  tmsf_pkg::tmsf_cmd_t           cmd;
  tmsf_pkg::tmsf_sts_t           sts;
  logic [tmsf_pkg::SAMPLE_W-1:0] out_value;

  // Take every register write at once; the user must write only between bursts (not enforced here).
  assign cfg_ready = 1'b1;

  // Pad the result up to whole bytes.
  assign out_tdata = {{(tmsf_pkg::TDATA_W - tmsf_pkg::SAMPLE_W){1'b0}}, out_value};

  // Sequencer: accept words, then drive finish, divide and output phases.
  tmsf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: config registers, running stats, serial divider, result word.
  tmsf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_sample (in_tdata[tmsf_pkg::SAMPLE_W-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .out_value (out_value)
  );

endmodule

`default_nettype wire
